// ----- rtl/fcb_pkg.sv -----
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared constants, command codes and cell-chain types of the bag core.
// ----------------------------------------------------------------------------
package fcb_pkg;

    // Capacity of the bag and width of one stored key
    localparam int CAPACITY = 8;
    localparam int KEY_BITS = 32;

    // Derived widths: slot index and entry count (count can reach CAPACITY)
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int CMD_W     = 2;
    localparam int KEYF_W    = 32;
    localparam int NUM_W     = 4;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // Search token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    freq;
        logic                found;
        logic [IDX_W-1:0]    slot;
        logic [KEY_BITS-1:0] last;
    } t_tok;

    // Slot write broadcast to all cells
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    idx;
        logic [KEY_BITS-1:0] data;
    } t_wr;

endpackage

// ----- rtl/fcb_cell.sv -----
// ----------------------------------------------------------------------------
// fcb_cell
// One bag slot: holds a key, compares it with the passing search token and
// hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module fcb_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [fcb_pkg::IDX_W-1:0] i_index,
    input  logic [fcb_pkg::CNT_W-1:0] i_count,
    input  fcb_pkg::t_tok         i_tok,
    input  fcb_pkg::t_wr          i_wr,
    output fcb_pkg::t_tok         o_tok
);
    import fcb_pkg::*;

    logic [KEY_BITS-1:0] r_entry;
    t_tok                r_tok;
    t_tok                n_tok;
    logic                w_held;
    logic                w_last;
    logic                w_hit;

    // Classify this slot against the current fill level
    assign w_held = CNT_W'(i_index) < i_count;
    assign w_last = (CNT_W'(i_index) + CNT_W'(1)) == i_count;
    assign w_hit  = i_tok.valid && w_held && (r_entry == i_tok.key);

    // Update the token as it passes
    always_comb begin
        n_tok      = i_tok;
        n_tok.freq = i_tok.freq + CNT_W'(w_hit);
        if (w_hit && !i_tok.found) begin
            n_tok.found = 1'b1;
            n_tok.slot  = i_index;
        end
        if (w_last) begin
            n_tok.last = r_entry;
        end
    end

    // Store a key when the write targets this slot
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_entry <= i_wr.data;
        end
    end

    // Advance the token; only its valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.key   <= n_tok.key;
        r_tok.freq  <= n_tok.freq;
        r_tok.found <= n_tok.found;
        r_tok.slot  <= n_tok.slot;
        r_tok.last  <= n_tok.last;
    end

    assign o_tok = r_tok;

endmodule

// ----- rtl/fixed_capacity_bag_core.sv -----
// ----------------------------------------------------------------------------
// fixed_capacity_bag_core
// Unordered bag of up to CAPACITY keys with add, remove, query and clear.
// ----------------------------------------------------------------------------
// Sequence: add and clear go from idle straight to the done state; remove and
//   query first pass the scan state while the search token walks the chain
//   one cell per cycle. In the done state the result is loaded into the output
//   register once it is free; a new command is accepted only in the idle state.
// Reset: synchronous, active low; clears the count and all handshake state.
//   Slot contents are not reset and are only read after being written.
// ----------------------------------------------------------------------------
module fixed_capacity_bag_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [fcb_pkg::S_DATA_W-1:0] s_axis_tdata,  // cmd[1:0], key[33:2], zero pad
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [fcb_pkg::M_DATA_W-1:0] m_axis_tdata   // ok[0], frequency[4:1],
                                                         // size[8:5], empty_res[9], pad
);
    import fcb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CMD_W-1:0]    r_cmd;
    logic                r_res_ok;
    logic                n_res_ok;
    logic [CNT_W-1:0]    r_res_freq;
    logic [CNT_W-1:0]    n_res_freq;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic [CMD_W-1:0]    w_cmd;
    logic [KEY_BITS-1:0] w_key;
    logic                w_in_acc;
    logic                w_load_out;
    logic [NUM_W-1:0]    w_size;
    t_wr                 w_wr;
    t_tok                w_tok [0:CAPACITY];

    // Unpack the input transaction
    assign w_cmd      = s_axis_tdata[CMD_W-1:0];
    assign w_key      = KEY_BITS'(s_axis_tdata[CMD_W +: KEYF_W]);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // Inject a search token at the head of the chain
    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = w_in_acc && ((w_cmd == CMD_REMOVE) || (w_cmd == CMD_QUERY));
        w_tok[0].key   = w_key;
    end

    // Row of slot cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        fcb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .i_wr    (w_wr),
            .o_tok   (w_tok[g+1])
        );
    end

    // Command sequencing, slot writes and count update
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_res_ok   = r_res_ok;
        n_res_freq = r_res_freq;
        w_wr       = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_res_ok   = 1'b0;
                    n_res_freq = '0;
                    case (w_cmd)
                        CMD_ADD: begin
                            n_state = ST_DONE;
                            if (r_count < CNT_W'(CAPACITY)) begin
                                w_wr.en   = 1'b1;
                                w_wr.idx  = r_count[IDX_W-1:0];
                                w_wr.data = w_key;
                                n_count   = r_count + CNT_W'(1);
                                n_res_ok  = 1'b1;
                            end
                        end
                        CMD_REMOVE, CMD_QUERY: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_state  = ST_DONE;
                            n_count  = '0;
                            n_res_ok = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_tok[CAPACITY].valid) begin
                    n_state = ST_DONE;
                    if (r_cmd == CMD_QUERY) begin
                        n_res_freq = w_tok[CAPACITY].freq;
                        n_res_ok   = (w_tok[CAPACITY].freq != '0);
                    end else if (w_tok[CAPACITY].found) begin
                        // Move the last entry into the freed slot
                        w_wr.en   = 1'b1;
                        w_wr.idx  = w_tok[CAPACITY].slot;
                        w_wr.data = w_tok[CAPACITY].last;
                        n_count   = r_count - CNT_W'(1);
                        n_res_ok  = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    assign w_size = NUM_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= w_cmd;
        end
        r_res_ok   <= n_res_ok;
        r_res_freq <= n_res_freq;
        if (w_load_out) begin
            r_out_data <= {6'd0, (r_count == '0), w_size, NUM_W'(r_res_freq), r_res_ok};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Count never exceeds the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("bag count above capacity");

    // A token leaves the chain only while a scan is running
    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[CAPACITY].valid |-> (r_state == ST_SCAN))
        else $error("search token left the chain outside a scan");

    // The empty flag agrees with the reported size
    a_empty_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9] == (m_axis_tdata[8:5] == 4'd0)))
        else $error("empty flag disagrees with size");

    // Count changes only when a command is accepted or a scan ends
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> $stable(r_count))
        else $error("count changed while a result was pending");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fixed_capacity_bag_core. A directed table covers an
// empty bag, duplicates, a full bag and clear. Random command streams then
// follow, biased toward a small set of keys so that hits and duplicates occur.
// Each result is checked against typed values or a behavioral bench bag, while
// both stream sides idle at random and the receiver once stalls for a long time.
// ----------------------------------------------------------------------------
module testbench;
    import fcb_pkg::*;

    // Result word as laid out in m_axis_tdata[9:0], msb first
    typedef struct packed {
        logic             empty_res;
        logic [NUM_W-1:0] size;
        logic [NUM_W-1:0] frequency;
        logic             ok;
    } bag_res_t;

    // One row of directed stimulus; chk selects the typed-in result
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEYF_W-1:0] key;
        bit                chk;
        logic              ok;
        logic [NUM_W-1:0]  frequency;
        logic [NUM_W-1:0]  size;
        logic              empty_res;
    } dir_row_t;

    localparam int N_DIR    = 25;
    localparam int N_RAND   = 1350;
    localparam int HOLD_LEN = 400;

    logic                clk_r   = 1'b0;
    logic                rst_n_r = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    wire                 i_clk   = clk_r;
    wire                 i_rst_n = rst_n_r;

    // Bench copy of the bag contents
    logic [KEY_BITS-1:0] bag_slots [CAPACITY];
    int                  bag_count = 0;

    bag_res_t pending_res [$];
    int       fail_cnt     = 0;
    int       checked_cnt  = 0;
    int       cmd_cnt [4]  = '{0, 0, 0, 0};
    int       full_rejects = 0;
    int       miss_removes = 0;
    int       dup_hits     = 0;
    bit       quiet        = 1'b0;
    bit       hold_go      = 1'b0;
    int       hold_left    = 0;

    // Directed stimulus: cmd, key, chk, ok, frequency, size, empty_res
    dir_row_t dir_tab [N_DIR] = '{
        '{CMD_QUERY,  32'h0000_0000, 1'b1, 1'b0, 4'd0, 4'd0, 1'b1},
        '{CMD_REMOVE, 32'h0000_0000, 1'b1, 1'b0, 4'd0, 4'd0, 1'b1},
        '{CMD_CLEAR,  32'h0000_0000, 1'b1, 1'b1, 4'd0, 4'd0, 1'b1},
        '{CMD_ADD,    32'h0000_0000, 1'b1, 1'b1, 4'd0, 4'd1, 1'b0},
        '{CMD_ADD,    32'hFFFF_FFFF, 1'b1, 1'b1, 4'd0, 4'd2, 1'b0},
        '{CMD_ADD,    32'h0000_0005, 1'b1, 1'b1, 4'd0, 4'd3, 1'b0},
        '{CMD_ADD,    32'h0000_0005, 1'b1, 1'b1, 4'd0, 4'd4, 1'b0},
        '{CMD_ADD,    32'h0000_0005, 1'b1, 1'b1, 4'd0, 4'd5, 1'b0},
        '{CMD_QUERY,  32'h0000_0005, 1'b1, 1'b1, 4'd3, 4'd5, 1'b0},
        '{CMD_ADD,    32'hAAAA_AAAA, 1'b1, 1'b1, 4'd0, 4'd6, 1'b0},
        '{CMD_ADD,    32'h5555_5555, 1'b1, 1'b1, 4'd0, 4'd7, 1'b0},
        '{CMD_ADD,    32'h8000_0000, 1'b1, 1'b1, 4'd0, 4'd8, 1'b0},
        '{CMD_ADD,    32'h0000_0001, 1'b1, 1'b0, 4'd0, 4'd8, 1'b0},
        '{CMD_QUERY,  32'h0000_0001, 1'b1, 1'b0, 4'd0, 4'd8, 1'b0},
        '{CMD_REMOVE, 32'h0000_0005, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0},
        '{CMD_QUERY,  32'h8000_0000, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0},
        '{CMD_REMOVE, 32'h0000_0005, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0},
        '{CMD_QUERY,  32'h0000_0005, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0},
        '{CMD_REMOVE, 32'h1234_5678, 1'b1, 1'b0, 4'd0, 4'd6, 1'b0},
        '{CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0},
        '{CMD_QUERY,  32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0, 4'd0, 1'b0},
        '{CMD_CLEAR,  32'hDEAD_BEEF, 1'b1, 1'b1, 4'd0, 4'd0, 1'b1},
        '{CMD_QUERY,  32'h0000_0005, 1'b1, 1'b0, 4'd0, 4'd0, 1'b1},
        '{CMD_ADD,    32'h0000_0007, 1'b1, 1'b1, 4'd0, 4'd1, 1'b0},
        '{CMD_REMOVE, 32'h0000_0007, 1'b1, 1'b1, 4'd0, 4'd0, 1'b1}
    };

    fixed_capacity_bag_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // cmd, key, zero pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // ok, frequency, size, empty_res, pad
    );

    always #5 clk_r = ~clk_r;

    // Apply one command to the bench bag and return the result it must give
    function automatic bag_res_t bag_apply(input logic [CMD_W-1:0] cmd,
                                           input logic [KEYF_W-1:0] key_in);
        logic [KEY_BITS-1:0] k;
        int                  hits;
        int                  slot;
        bag_res_t            r;
        k    = KEY_BITS'(key_in);
        hits = 0;
        slot = -1;
        r    = '0;
        case (cmd)
            CMD_ADD: begin
                if (bag_count < CAPACITY) begin
                    bag_slots[bag_count] = k;
                    bag_count++;
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                // lowest matching slot takes the last entry
                for (int i = 0; i < bag_count; i++)
                    if (slot < 0 && bag_slots[i] == k) slot = i;
                if (slot >= 0) begin
                    bag_count--;
                    bag_slots[slot] = bag_slots[bag_count];
                    r.ok = 1'b1;
                end
            end
            CMD_QUERY: begin
                for (int i = 0; i < bag_count; i++)
                    if (bag_slots[i] == k) hits++;
                r.frequency = NUM_W'(hits);
                r.ok        = (hits > 0);
            end
            default: begin
                bag_count = 0;
                r.ok      = 1'b1;
            end
        endcase
        r.size      = NUM_W'(bag_count);
        r.empty_res = (bag_count == 0);
        return r;
    endfunction

    // Offer one command, wait for its transaction and queue its result
    task automatic issue_cmd(input logic [CMD_W-1:0] cmd, input logic [KEYF_W-1:0] key,
                             input bit chk, input bag_res_t typed);
        logic [S_DATA_W-1:0] word;
        bag_res_t            model_res;
        word                     = '0;
        word[CMD_W-1:0]          = cmd;
        word[CMD_W +: KEYF_W]    = key;
        if (!quiet) begin
            while ($urandom_range(0, 99) < 9) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        model_res = bag_apply(cmd, key);
        pending_res.push_back(chk ? typed : model_res);
        cmd_cnt[cmd]++;
        if (cmd == CMD_ADD && !model_res.ok) full_rejects++;
        if (cmd == CMD_REMOVE && !model_res.ok) miss_removes++;
        if (cmd == CMD_QUERY && model_res.frequency > 1) dup_hits++;
    endtask

    // Receiver: random stalls, one long hold on request, none while quiet
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 9);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        bag_res_t got;
        bag_res_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = bag_res_t'(m_axis_tdata[9:0]);
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fail_cnt++;
            end else begin
                want = pending_res.pop_front();
                checked_cnt++;
                if (got.ok !== want.ok) begin
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
                    fail_cnt++;
                end
                if (got.frequency !== want.frequency) begin
                    $display("%0t: frequency expected %0d actual %0d",
                             $time, want.frequency, got.frequency);
                    fail_cnt++;
                end
                if (got.size !== want.size) begin
                    $display("%0t: size expected %0d actual %0d", $time, want.size, got.size);
                    fail_cnt++;
                end
                if (got.empty_res !== want.empty_res) begin
                    $display("%0t: empty_res expected %0d actual %0d",
                             $time, want.empty_res, got.empty_res);
                    fail_cnt++;
                end
            end
        end
    end

    // Main stimulus
    initial begin
        bag_res_t            typed;
        logic [CMD_W-1:0]    cmd;
        logic [KEYF_W-1:0]   key;
        int                  pick;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        rst_n_r <= 1'b1;

        // directed table
        foreach (dir_tab[i]) begin
            typed.ok        = dir_tab[i].ok;
            typed.frequency = dir_tab[i].frequency;
            typed.size      = dir_tab[i].size;
            typed.empty_res = dir_tab[i].empty_res;
            issue_cmd(dir_tab[i].cmd, dir_tab[i].key, dir_tab[i].chk, typed);
        end

        // random commands, keys mostly from a small pool to get hits
        for (int n = 0; n < N_RAND; n++) begin
            quiet = (n >= 500 && n < 800);
            if (n == 200) hold_go = 1'b1;
            if (n == 900) begin
                // drop the offer and drain everything before going on
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (pending_res.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)      cmd = CMD_ADD;
            else if (pick < 65) cmd = CMD_REMOVE;
            else if (pick < 95) cmd = CMD_QUERY;
            else                cmd = CMD_CLEAR;
            pick = $urandom_range(0, 9);
            if (pick < 6)       key = $urandom_range(0, 5);
            else if (pick < 9)  key = $urandom;
            else begin
                case ($urandom_range(0, 2))
                    0:       key = '0;
                    1:       key = '1;
                    default: key = 32'h1 << $urandom_range(0, 31);
                endcase
            end
            issue_cmd(cmd, key, 1'b0, '0);
        end
        quiet = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain, then let a late extra result show up
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 10) @(posedge i_clk);

        $display("Ran %0d commands: add %0d, remove %0d, query %0d, clear %0d; %0d results checked",
                 N_DIR + N_RAND, cmd_cnt[CMD_ADD], cmd_cnt[CMD_REMOVE], cmd_cnt[CMD_QUERY],
                 cmd_cnt[CMD_CLEAR], checked_cnt);
        $display("Adds to a full bag: %0d, removes of absent keys: %0d, duplicate hits: %0d",
                 full_rejects, miss_removes, dup_hits);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
